### src/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg: shared types and codes of the first-fit chunk allocator
// Request and result codes, register indexes and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_FREE    = 2'd1;
	localparam logic [1:0] ACT_REALLOC = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	localparam logic CFG_HEAP_START = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_OOM     = 3'd2,
		ST_FULL    = 3'd3,
		ST_DOUBLE  = 3'd4,
		ST_UNKNOWN = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		RES_NULL = 2'd0,
		RES_HIT  = 2'd1,
		RES_USER = 2'd2,
		RES_REQ  = 2'd3
	} res_sel_t;

	typedef enum logic [2:0] {
		WR_NONE     = 3'd0,
		WR_HIT_BUSY = 3'd1,
		WR_HIT_FREE = 3'd2,
		WR_OLD_FREE = 3'd3,
		WR_NEW      = 3'd4
	} wr_kind_t;

	typedef struct packed {
		logic     req_load;
		logic     scan_go;
		logic     scan_fit;
		logic     mod_go;
		logic     calc;
		logic     save_old;
		wr_kind_t wr_kind;
		logic     set_res;
		res_sel_t res_sel;
		status_t  res_st;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       size_zero;
		logic       addr_zero;
		logic       scan_done;
		logic       scan_hit;
		logic       hit_free;
		logic       fits_hit;
		logic       mod_done;
		logic       oom;
		logic       full;
		logic       out_busy;
	} stat_t;

endpackage

### src/ffca_if.sv
// ----------------------------------------------------------------------------
// ffca_req_if / ffca_rsp_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ffca_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] request_size;
	logic [31:0] address;

	modport source (output valid, action, request_size, address, input ready);
	modport sink (input valid, action, request_size, address, output ready);
endinterface

interface ffca_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_address;
	logic [2:0]  status;

	modport source (output valid, result_address, status, input ready);
	modport sink (input valid, result_address, status, output ready);
endinterface

### src/first_fit_chunk_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator: first-fit heap bookkeeping engine
// Requests (allocate, free, reallocate) arrive on the req channel; each gives
// exactly one result (address and status) on the rsp channel.
// One request is in work at a time. A free or a reallocate looks up the
// address by walking the chunk table, one entry a cycle. An allocate walks
// the freed chunks the same way; when no chunk fits, it waits for the
// alignment remainder unit (one byte a cycle, started with the walk) and
// carves a chunk at the break.
// A growing reallocate does a lookup and then an allocate back to back.
// The table read port sets the walk to one entry a cycle.
// A result sits in an output register; the next request is taken while it
// waits. When the receiver stalls and a second result is ready, the block
// holds it and takes no more requests until the register drains.
// Reset empties the table, clears the break to zero and sets the heap limit to
// all ones; no clearing pass is needed. The user makes configuration writes
// (cfg_we, cfg_index, cfg_data) while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator #(
	parameter int TABLE_DEPTH  = 64,
	parameter int CHUNK_ALIGN  = 16,
	parameter int HEADER_BYTES = 24,
	parameter int GUARD_BYTES  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	ffca_req_if.sink    req,
	ffca_rsp_if.source  rsp
);

	ffca_pkg::cmd_t  cmd;
	ffca_pkg::stat_t stat;

	ffca_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ffca_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.CHUNK_ALIGN (CHUNK_ALIGN),
		.HEADER_BYTES(HEADER_BYTES),
		.GUARD_BYTES (GUARD_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_action  (req.action),
		.in_size    (req.request_size),
		.in_address (req.address),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_address(rsp.result_address),
		.out_status (rsp.status)
	);

`ifndef NO_ASSERTIONS
	// one request in work: no transfer right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in work");

	// a result is loaded only into a free output register
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("result overwrote a pending result");

	// a new chunk is never written into a full table
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_kind == ffca_pkg::WR_NEW |-> !stat.full && !stat.oom)
		else $error("chunk carved past table or heap limit");
`endif

endmodule

### src/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/ffca_dp.sv
// ----------------------------------------------------------------------------
// ffca_dp: allocator datapath
// Chunk table, table scan, alignment remainder, break and result registers.
// ----------------------------------------------------------------------------
module ffca_dp #(
	parameter int TABLE_DEPTH  = 64,
	parameter int CHUNK_ALIGN  = 16,
	parameter int HEADER_BYTES = 24,
	parameter int GUARD_BYTES  = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffca_pkg::cmd_t  cmd,
	output ffca_pkg::stat_t stat,
	input  logic [1:0]      in_action,
	input  logic [31:0]     in_size,
	input  logic [31:0]     in_address,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     out_address,
	output logic [2:0]      out_status
);

	localparam int IDXW = $clog2(TABLE_DEPTH);
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int BW   = 34;
	localparam int NDIG = 5;
	localparam int XW   = 8 * NDIG;
	localparam int VW   = 14;
	localparam int MW   = VW + 2;
	localparam int RW   = 7;
	localparam int SW   = $clog2(NDIG + 1);
	localparam int LG   = $clog2(CHUNK_ALIGN);
	localparam int SH   = VW + LG;
	localparam int EW   = 65;
	localparam longint unsigned MUL_L = ((64'd1 << SH) / CHUNK_ALIGN) + 64'd1;
	localparam logic [MW-1:0]   MUL_C   = MW'(MUL_L);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(TABLE_DEPTH);
	localparam logic [RW-1:0]   ALIGN_R = RW'(CHUNK_ALIGN);
	localparam logic [BW-1:0]   HG_C    = BW'(HEADER_BYTES + GUARD_BYTES);
	localparam logic [BW-1:0]   HGG_C   = BW'(HEADER_BYTES + 2 * GUARD_BYTES);

	// request
	logic [1:0]  act_q;
	logic [31:0] size_q;
	logic [31:0] addr_q;

	// configuration and heap state
	logic [31:0]     heap_limit_q;
	logic [31:0]     bp_q;
	logic [CNTW-1:0] cnt_q;

	// scan engine
	logic            busy_q;
	logic            fit_q;
	logic            pend_q;
	logic [IDXW-1:0] pend_idx_q;
	logic [CNTW-1:0] rd_idx_q;
	logic            done_q;
	logic            hit_q;
	logic [IDXW-1:0] hit_idx_q;
	logic [31:0]     hit_ua_q;
	logic [31:0]     hit_by_q;
	logic            hit_fr_q;
	logic [IDXW-1:0] old_idx_q;
	logic [31:0]     old_ua_q;
	logic [31:0]     old_by_q;

	// alignment remainder
	logic [XW-1:0]      sh_q;
	logic [RW-1:0]      rem_q;
	logic [SW-1:0]      step_q;
	logic [VW-1:0]      mv;
	logic [2*VW+1:0]    mprod;
	logic [VW-1:0]      mq;
	logic [VW+RW-1:0]   mqa;
	logic [VW+RW-1:0]   mdiff;
	logic [RW-1:0]      mrem;
	logic [RW-1:0]      pad;

	// carve results
	logic [31:0]   user_q;
	logic [BW-1:0] nb_q;

	// result and output
	logic [31:0] res_addr_q;
	logic [2:0]  res_st_q;
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	logic [2:0]  out_st_q;

	// RAM
	logic            we;
	logic [IDXW-1:0] waddr;
	logic [EW-1:0]   wdata;
	logic [EW-1:0]   rdata;
	logic [31:0]     r_ua;
	logic [31:0]     r_by;
	logic            r_fr;
	logic            match;
	logic            issue;
	logic            miss_end;

	ffca_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_idx_q[IDXW-1:0]),
		.rdata(rdata)
	);

	assign r_ua = rdata[64:33];
	assign r_by = rdata[32:1];
	assign r_fr = rdata[0];

	// compare the entry read in the previous cycle
	assign match    = pend_q && (fit_q ? (r_fr && (r_by >= size_q)) : (r_ua == addr_q));
	assign issue    = busy_q && (rd_idx_q < cnt_q) && !match;
	assign miss_end = busy_q && !match && (rd_idx_q == cnt_q);

	// table write selection
	always_comb begin
		we    = 1'b1;
		waddr = hit_idx_q;
		wdata = {hit_ua_q, hit_by_q, 1'b0};
		case (cmd.wr_kind)
			ffca_pkg::WR_HIT_BUSY: wdata = {hit_ua_q, hit_by_q, 1'b0};
			ffca_pkg::WR_HIT_FREE: wdata = {hit_ua_q, hit_by_q, 1'b1};
			ffca_pkg::WR_OLD_FREE: begin
				waddr = old_idx_q;
				wdata = {old_ua_q, old_by_q, 1'b1};
			end
			ffca_pkg::WR_NEW: begin
				waddr = cnt_q[IDXW-1:0];
				wdata = {user_q, size_q, 1'b0};
			end
			default: we = 1'b0;
		endcase
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			act_q  <= in_action;
			size_q <= in_size;
			addr_q <= in_address;
		end
	end

	// configuration, break and chunk count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= 32'hFFFF_FFFF;
			bp_q         <= 32'd0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we && cfg_index == ffca_pkg::CFG_HEAP_START) begin
				if (cnt_q == '0) begin
					bp_q <= cfg_data;
				end
			end
			if (cfg_we && cfg_index == ffca_pkg::CFG_HEAP_LIMIT) begin
				heap_limit_q <= cfg_data;
			end
			if (cmd.wr_kind == ffca_pkg::WR_NEW) begin
				cnt_q <= cnt_q + CNTW'(1);
				bp_q  <= nb_q[31:0];
			end
		end
	end

	// scan control: issue one read a cycle, stop at the first match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (cmd.scan_go) begin
			busy_q <= 1'b1;
			pend_q <= 1'b0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			pend_q <= issue;
			if (match || miss_end) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				hit_q  <= match;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.scan_go) begin
			fit_q    <= cmd.scan_fit;
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CNTW'(1);
		end
		pend_idx_q <= rd_idx_q[IDXW-1:0];
		if (match) begin
			hit_idx_q <= pend_idx_q;
			hit_ua_q  <= r_ua;
			hit_by_q  <= r_by;
			hit_fr_q  <= r_fr;
		end
		if (cmd.save_old) begin
			old_idx_q <= hit_idx_q;
			old_ua_q  <= hit_ua_q;
			old_by_q  <= hit_by_q;
		end
	end

	// remainder of the break plus header and guard, one byte a cycle:
	// fold the byte into the running remainder, reduce by reciprocal multiply
	assign mv    = {rem_q[RW-2:0], sh_q[XW-1 -: 8]};
	assign mprod = {{MW{1'b0}}, mv} * {{VW{1'b0}}, MUL_C};
	assign mq    = VW'(mprod >> SH);
	assign mqa   = {{RW{1'b0}}, mq} * {{VW{1'b0}}, ALIGN_R};
	assign mdiff = {{RW{1'b0}}, mv} - mqa;
	assign mrem  = mdiff[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.mod_go) begin
			step_q <= SW'(NDIG);
		end else if (step_q != '0) begin
			step_q <= step_q - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_go) begin
			sh_q  <= {{(XW - BW){1'b0}}, {{(BW - 32){1'b0}}, bp_q} + HG_C};
			rem_q <= '0;
		end else if (step_q != '0) begin
			sh_q  <= {sh_q[XW-9:0], 8'd0};
			rem_q <= mrem;
		end
	end

	assign pad = (rem_q == '0) ? '0 : ALIGN_R - rem_q;

	// user address and next break of a new chunk
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			user_q <= bp_q + HG_C[31:0] + {{(32 - RW){1'b0}}, pad};
			nb_q   <= {{(BW - 32){1'b0}}, bp_q} + HGG_C + {{(BW - RW){1'b0}}, pad}
				+ {{(BW - 32){1'b0}}, size_q};
		end
	end

	// result
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_st_q <= cmd.res_st;
			case (cmd.res_sel)
				ffca_pkg::RES_HIT:  res_addr_q <= hit_ua_q;
				ffca_pkg::RES_USER: res_addr_q <= user_q;
				ffca_pkg::RES_REQ:  res_addr_q <= addr_q;
				default:            res_addr_q <= 32'd0;
			endcase
		end
		if (cmd.out_load) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	// output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_address = out_addr_q;
	assign out_status  = out_st_q;

	assign stat.act       = act_q;
	assign stat.size_zero = (size_q == 32'd0);
	assign stat.addr_zero = (addr_q == 32'd0);
	assign stat.scan_done = done_q;
	assign stat.scan_hit  = hit_q;
	assign stat.hit_free  = hit_fr_q;
	assign stat.fits_hit  = (size_q <= hit_by_q);
	assign stat.mod_done  = (step_q == '0);
	assign stat.oom       = (nb_q > {{(BW - 32){1'b0}}, heap_limit_q});
	assign stat.full      = (cnt_q == DEPTH_C);
	assign stat.out_busy  = out_valid_q && !out_ready;

endmodule

### src/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl: allocator controller
// Sequences lookups, first-fit searches, carving and table updates.
// ----------------------------------------------------------------------------
module ffca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffca_pkg::stat_t stat,
	output ffca_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_FIND   = 8'b0000_0100,
		S_FIT    = 8'b0000_1000,
		S_MOD    = 8'b0001_0000,
		S_COMMIT = 8'b0010_0000,
		S_WROLD  = 8'b0100_0000,
		S_RESP   = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;
	logic   grow_q, grow_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grow_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			grow_q  <= grow_n;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_n = state_q;
		grow_n  = grow_q;
		cmd     = '0;
		cmd.wr_kind = ffca_pkg::WR_NONE;
		cmd.res_sel = ffca_pkg::RES_NULL;
		cmd.res_st  = ffca_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_n      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_res = 1'b1;
				state_n     = S_RESP;
				case (stat.act)
					ffca_pkg::ACT_ALLOC, ffca_pkg::ACT_REALLOC: begin
						if (stat.act == ffca_pkg::ACT_REALLOC && !stat.addr_zero) begin
							cmd.set_res = 1'b0;
							cmd.scan_go = 1'b1;
							state_n     = S_FIND;
						end else if (stat.size_zero) begin
							cmd.res_st = ffca_pkg::ST_ZERO;
						end else begin
							cmd.set_res  = 1'b0;
							cmd.scan_go  = 1'b1;
							cmd.scan_fit = 1'b1;
							cmd.mod_go   = 1'b1;
							state_n      = S_FIT;
						end
					end
					ffca_pkg::ACT_FREE: begin
						if (!stat.addr_zero) begin
							cmd.set_res = 1'b0;
							cmd.scan_go = 1'b1;
							state_n     = S_FIND;
						end
					end
					default: ;
				endcase
			end
			S_FIND: begin
				if (stat.scan_done) begin
					cmd.set_res = 1'b1;
					state_n     = S_RESP;
					if (!stat.scan_hit) begin
						cmd.res_st = ffca_pkg::ST_UNKNOWN;
					end else if (stat.hit_free) begin
						cmd.res_st = ffca_pkg::ST_DOUBLE;
					end else if (stat.act == ffca_pkg::ACT_FREE) begin
						cmd.wr_kind = ffca_pkg::WR_HIT_FREE;
					end else if (stat.fits_hit) begin
						cmd.res_sel = ffca_pkg::RES_REQ;
					end else begin
						// grow: search anew, free the old chunk on success
						cmd.set_res  = 1'b0;
						cmd.save_old = 1'b1;
						cmd.scan_go  = 1'b1;
						cmd.scan_fit = 1'b1;
						cmd.mod_go   = 1'b1;
						grow_n       = 1'b1;
						state_n      = S_FIT;
					end
				end
			end
			S_FIT: begin
				if (stat.scan_done) begin
					if (stat.scan_hit) begin
						cmd.wr_kind = ffca_pkg::WR_HIT_BUSY;
						cmd.set_res = 1'b1;
						cmd.res_sel = ffca_pkg::RES_HIT;
						state_n     = grow_q ? S_WROLD : S_RESP;
					end else begin
						state_n = S_MOD;
					end
				end
			end
			S_MOD: begin
				if (stat.mod_done) begin
					cmd.calc = 1'b1;
					state_n  = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.set_res = 1'b1;
				state_n     = S_RESP;
				if (stat.oom) begin
					cmd.res_st = ffca_pkg::ST_OOM;
				end else if (stat.full) begin
					cmd.res_st = ffca_pkg::ST_FULL;
				end else begin
					cmd.wr_kind = ffca_pkg::WR_NEW;
					cmd.res_sel = ffca_pkg::RES_USER;
					state_n     = grow_q ? S_WROLD : S_RESP;
				end
			end
			S_WROLD: begin
				cmd.wr_kind = ffca_pkg::WR_OLD_FREE;
				state_n     = S_RESP;
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					grow_n       = 1'b0;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

endmodule
